### sv/lfbr_pkg.sv
// ----------------------------------------------------------------------------
// lfbr_pkg
// shared constants and types for the lpc tap build and residual engine
// ----------------------------------------------------------------------------
package lfbr_pkg;

   localparam int MAX_ORDER = 256;
   localparam int ADDR_W    = $clog2(MAX_ORDER);
   localparam int ORD_W     = $clog2(MAX_ORDER + 1);

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [ORD_W-1:0]  ord_type;

   // command codes
   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_BUILD  = 2'd1;
   localparam logic [1:0] CMD_SAMPLE = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_ORDER        = 2'd0;
   localparam logic [1:0] CSR_QUANT_SHIFT  = 2'd1;
   localparam logic [1:0] CSR_SAMPLE_SHIFT = 2'd2;

   // register reset values
   localparam logic [8:0] ORDER_RST        = 9'd32;
   localparam logic [3:0] QUANT_SHIFT_RST  = 4'd10;
   localparam logic [4:0] SAMPLE_SHIFT_RST = 5'd0;

   // prediction clip bounds
   localparam logic signed [31:0] CLIP_LO = -32'sd8192;
   localparam logic signed [31:0] CLIP_HI = 32'sd8191;

endpackage

### sv/lfbr_ram.sv
// ----------------------------------------------------------------------------
// lfbr_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module lfbr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### sv/lfbr_mul.sv
// ----------------------------------------------------------------------------
// lfbr_mul
// shared signed 32 x 16 multiplier with registered product
// ----------------------------------------------------------------------------
module lfbr_mul (
   input  logic               clock,
   input  logic signed [31:0] mul_a,
   input  logic signed [15:0] mul_b,
   output logic signed [47:0] product_ff
);

   always_ff @(posedge clock) begin
      product_ff <= 48'(mul_a) * 48'(mul_b);
   end

endmodule

### sv/lpc_filter_build_and_residual.sv
// ----------------------------------------------------------------------------
// lpc_filter_build_and_residual
// lpc tap builder and prediction residual engine
// ----------------------------------------------------------------------------
// channels: req_ takes one word per command (load predictor, build taps,
// sample), rsp_ returns one residual word per sample past warm-up, csr_
// writes order, quant_shift and sample_shift (always ready, write only
// while the block is idle).
// a load word is written as it is accepted. a build word runs the lattice
// recursion on one shared multiplier: each order step reads its predictor,
// updates the entry pairs in turn (two reads, two products, two writes)
// and then stores its own entry; the taps are then converted one by one,
// each from a lattice read and a tap write. a sample word sweeps the
// history and tap memories once, one tap per cycle on the shared
// multiplier, and a residual past warm-up goes to the output register.
// the rate is set by the single multiplier and the one read port of
// each memory. req_ready is high only while idle.
// reset clears the sequencer, warm-up count and output valid, and loads
// the registers' reset values; memories keep their contents, not cleared.
// the result sits in an output register; a stalled receiver holds the
// next sample only at its final step, when its result has nowhere to go.
// ----------------------------------------------------------------------------
module lpc_filter_build_and_residual (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_cmd,
   input  logic [7:0]         req_coef_index,
   input  logic signed [9:0]  req_predictor_value,
   input  logic signed [31:0] req_sample,
   input  logic               req_is_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_residual,
   output logic               rsp_last_out,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [8:0]         csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_B_PRED, ST_B_PREDW, ST_B_RD1, ST_B_RD2, ST_B_M1, ST_B_M2,
      ST_B_W2, ST_B_PUT, ST_C_RD, ST_C_WR, ST_S_RUN, ST_S_FIN
   } state_type;

   state_type state_ff;

   // configuration
   logic [8:0] order_ff;
   logic [3:0] quant_ff;
   logic [4:0] shift_ff;

   // sequencer counters
   lfbr_pkg::ord_type i_ff, j_ff, k_ff, c_ff, d_idx_ff, warmup_ff;
   logic              d_valid_ff, p_valid_ff;

   // lattice operands
   logic signed [9:0]  p_ff;
   logic [31:0]        v1_ff, v2_ff, t1_ff, t2_ff;
   logic [31:0]        acc_ff;
   logic signed [31:0] sample_ff;
   logic               last_ff;

   // output register
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_residual_ff;
   logic               rsp_last_ff;

   // memory ports
   logic                  pred_we, lw_we, tap_we, hist_we;
   lfbr_pkg::addr_type    pred_waddr, lw_waddr, lw_raddr, tap_waddr, hist_waddr;
   lfbr_pkg::addr_type    run_addr;
   logic [9:0]            pred_rdata;
   logic [31:0]           lw_wdata, lw_rdata;
   logic [15:0]           tap_wdata, tap_rdata, hist_wdata, hist_rdata;

   // shared multiplier
   logic signed [31:0] mul_a;
   logic signed [15:0] mul_b;
   logic signed [47:0] product;
   logic signed [47:0] term_sum;
   logic [31:0]        term;

   // derived values
   lfbr_pkg::ord_type eff_order, pairs, mirror, last_idx;
   logic [3:0]        eff_quant, tap_shift;
   logic [31:0]       round_y, round_sum, tap_wide;
   logic signed [31:0] tap_shifted, pred_shifted, pred_clip, residual;
   logic [15:0]        hist_new;
   logic               accept, warm, out_free, fin_fire, run_issue, run_done;
   logic               rsp_load;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   // effective order and quant shift with out of range values pinned
   always_comb begin
      if (order_ff == 9'd0) begin
         eff_order = lfbr_pkg::ord_type'(1);
      end else if (32'(order_ff) > lfbr_pkg::MAX_ORDER) begin
         eff_order = lfbr_pkg::ord_type'(lfbr_pkg::MAX_ORDER);
      end else begin
         eff_order = lfbr_pkg::ord_type'(order_ff);
      end
      if (quant_ff == 4'd0) begin
         eff_quant = 4'd1;
      end else if (quant_ff == 4'd15) begin
         eff_quant = 4'd14;
      end else begin
         eff_quant = quant_ff;
      end
   end

   assign tap_shift = 4'd15 - eff_quant;
   assign pairs     = lfbr_pkg::ord_type'((i_ff + 1'b1) >> 1);
   assign mirror    = i_ff - 1'b1 - j_ff;
   assign last_idx  = eff_order - 1'b1;
   assign run_addr  = c_ff[lfbr_pkg::ADDR_W-1:0];
   assign run_issue = (c_ff < eff_order);
   assign run_done  = !run_issue && !d_valid_ff && !p_valid_ff;

   // lattice term: round, arithmetic shift by nine, keep 32 bits
   assign term_sum = product + 48'sd256;
   assign term     = term_sum[40:9];

   // tap conversion from lattice entry
   assign round_y     = 32'd1 << (tap_shift - 4'd1);
   assign round_sum   = lw_rdata + round_y;
   assign tap_shifted = $signed(round_sum) >>> tap_shift;
   assign tap_wide    = 32'd0 - tap_shifted;

   // history entry and prediction
   assign hist_new     = 16'($signed(sample_ff) >>> shift_ff);
   assign pred_shifted = $signed(acc_ff) >>> eff_quant;
   always_comb begin
      if (pred_shifted < lfbr_pkg::CLIP_LO) begin
         pred_clip = lfbr_pkg::CLIP_LO;
      end else if (pred_shifted > lfbr_pkg::CLIP_HI) begin
         pred_clip = lfbr_pkg::CLIP_HI;
      end else begin
         pred_clip = pred_shifted;
      end
   end
   assign residual = (pred_clip <<< shift_ff) - sample_ff;

   assign warm     = (32'(warmup_ff) < 32'(eff_order));
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign fin_fire = (state_ff == ST_S_FIN) && (warm || out_free);
   assign rsp_load = fin_fire && !warm;

   // predictor store writes
   assign pred_we    = accept && (req_cmd == lfbr_pkg::CMD_LOAD) &&
                       (32'(req_coef_index) < lfbr_pkg::MAX_ORDER);
   assign pred_waddr = lfbr_pkg::addr_type'(req_coef_index);

   // lattice work port selection
   always_comb begin
      lw_we    = 1'b0;
      lw_waddr = j_ff[lfbr_pkg::ADDR_W-1:0];
      lw_wdata = v1_ff + t2_ff;
      lw_raddr = j_ff[lfbr_pkg::ADDR_W-1:0];
      unique case (state_ff)
         ST_B_RD2: begin
            lw_raddr = mirror[lfbr_pkg::ADDR_W-1:0];
         end
         ST_B_M2: begin
            lw_we    = 1'b1;
            lw_waddr = mirror[lfbr_pkg::ADDR_W-1:0];
            lw_wdata = v2_ff + t1_ff;
         end
         ST_B_W2: begin
            lw_we = 1'b1;
         end
         ST_B_PUT: begin
            lw_we    = 1'b1;
            lw_waddr = i_ff[lfbr_pkg::ADDR_W-1:0];
            lw_wdata = {{16{p_ff[9]}}, p_ff, 6'b0};
         end
         ST_C_RD: begin
            lw_raddr = lfbr_pkg::addr_type'(last_idx - k_ff);
         end
         default: begin
         end
      endcase
   end

   assign tap_we    = (state_ff == ST_C_WR);
   assign tap_waddr = k_ff[lfbr_pkg::ADDR_W-1:0];
   assign tap_wdata = tap_wide[15:0];

   // history shifts down by one during the sweep, newest lands at the top
   always_comb begin
      if (state_ff == ST_S_FIN) begin
         hist_we    = fin_fire;
         hist_waddr = last_idx[lfbr_pkg::ADDR_W-1:0];
         hist_wdata = hist_new;
      end else begin
         hist_we    = (state_ff == ST_S_RUN) && d_valid_ff && (d_idx_ff != '0);
         hist_waddr = lfbr_pkg::addr_type'(d_idx_ff - 1'b1);
         hist_wdata = hist_rdata;
      end
   end

   // shared multiplier operands
   always_comb begin
      if (state_ff == ST_S_RUN) begin
         mul_a = {{16{hist_rdata[15]}}, hist_rdata};
         mul_b = tap_rdata;
      end else begin
         mul_a = lw_rdata;
         mul_b = {{6{p_ff[9]}}, p_ff};
      end
   end

   lfbr_ram #(.WIDTH(10), .DEPTH(lfbr_pkg::MAX_ORDER)) u_pred_ram (
      .clock   (clock),
      .wr_en   (pred_we),
      .wr_addr (pred_waddr),
      .wr_data (req_predictor_value),
      .rd_addr (i_ff[lfbr_pkg::ADDR_W-1:0]),
      .rd_data (pred_rdata)
   );

   lfbr_ram #(.WIDTH(32), .DEPTH(lfbr_pkg::MAX_ORDER)) u_lattice_ram (
      .clock   (clock),
      .wr_en   (lw_we),
      .wr_addr (lw_waddr),
      .wr_data (lw_wdata),
      .rd_addr (lw_raddr),
      .rd_data (lw_rdata)
   );

   lfbr_ram #(.WIDTH(16), .DEPTH(lfbr_pkg::MAX_ORDER)) u_tap_ram (
      .clock   (clock),
      .wr_en   (tap_we),
      .wr_addr (tap_waddr),
      .wr_data (tap_wdata),
      .rd_addr (run_addr),
      .rd_data (tap_rdata)
   );

   lfbr_ram #(.WIDTH(16), .DEPTH(lfbr_pkg::MAX_ORDER)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_waddr),
      .wr_data (hist_wdata),
      .rd_addr (run_addr),
      .rd_data (hist_rdata)
   );

   lfbr_mul u_mul (
      .clock      (clock),
      .mul_a      (mul_a),
      .mul_b      (mul_b),
      .product_ff (product)
   );

   // sequencer, counters and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         order_ff     <= lfbr_pkg::ORDER_RST;
         quant_ff     <= lfbr_pkg::QUANT_SHIFT_RST;
         shift_ff     <= lfbr_pkg::SAMPLE_SHIFT_RST;
         warmup_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         d_valid_ff   <= 1'b0;
         p_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               lfbr_pkg::CSR_ORDER:        order_ff <= csr_wdata;
               lfbr_pkg::CSR_QUANT_SHIFT:  quant_ff <= csr_wdata[3:0];
               lfbr_pkg::CSR_SAMPLE_SHIFT: shift_ff <= csr_wdata[4:0];
               default: begin
               end
            endcase
         end

         // a new residual replaces one that leaves in the same cycle
         if (rsp_load) begin
            rsp_valid_ff    <= 1'b1;
            rsp_residual_ff <= residual;
            rsp_last_ff     <= last_ff;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  sample_ff <= req_sample;
                  last_ff   <= req_is_last;
                  if (req_cmd == lfbr_pkg::CMD_BUILD) begin
                     i_ff      <= '0;
                     warmup_ff <= '0;
                     state_ff  <= ST_B_PRED;
                  end else if (req_cmd == lfbr_pkg::CMD_SAMPLE) begin
                     c_ff       <= '0;
                     d_valid_ff <= 1'b0;
                     p_valid_ff <= 1'b0;
                     acc_ff     <= 32'd1 << (eff_quant - 4'd1);
                     state_ff   <= ST_S_RUN;
                  end
               end
            end
            ST_B_PRED: begin
               state_ff <= ST_B_PREDW;
            end
            ST_B_PREDW: begin
               p_ff <= pred_rdata;
               j_ff <= '0;
               state_ff <= (i_ff == '0) ? ST_B_PUT : ST_B_RD1;
            end
            ST_B_RD1: begin
               state_ff <= ST_B_RD2;
            end
            ST_B_RD2: begin
               v1_ff    <= lw_rdata;
               state_ff <= ST_B_M1;
            end
            ST_B_M1: begin
               v2_ff    <= lw_rdata;
               t1_ff    <= term;
               state_ff <= ST_B_M2;
            end
            ST_B_M2: begin
               t2_ff    <= term;
               state_ff <= ST_B_W2;
            end
            ST_B_W2: begin
               j_ff     <= j_ff + 1'b1;
               state_ff <= ((j_ff + 1'b1) == pairs) ? ST_B_PUT : ST_B_RD1;
            end
            ST_B_PUT: begin
               if ((i_ff + 1'b1) == eff_order) begin
                  k_ff     <= '0;
                  state_ff <= ST_C_RD;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= ST_B_PRED;
               end
            end
            ST_C_RD: begin
               state_ff <= ST_C_WR;
            end
            ST_C_WR: begin
               k_ff     <= k_ff + 1'b1;
               state_ff <= ((k_ff + 1'b1) == eff_order) ? ST_IDLE : ST_C_RD;
            end
            ST_S_RUN: begin
               if (run_issue) begin
                  c_ff <= c_ff + 1'b1;
               end
               d_valid_ff <= run_issue;
               d_idx_ff   <= c_ff;
               p_valid_ff <= d_valid_ff;
               if (p_valid_ff) begin
                  acc_ff <= acc_ff + product[31:0];
               end
               if (run_done) begin
                  state_ff <= ST_S_FIN;
               end
            end
            ST_S_FIN: begin
               if (fin_fire) begin
                  if (last_ff) begin
                     warmup_ff <= '0;
                  end else if (warm) begin
                     warmup_ff <= warmup_ff + 1'b1;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_residual = rsp_residual_ff;
   assign rsp_last_out = rsp_last_ff;

`ifndef SYNTH
   // conversion writes always follow their lattice read
   a_conv_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_C_WR) |-> ($past(state_ff) == ST_C_RD))
      else $error("tap write without lattice read");

   // products only enter the accumulator in the cycle after read data
   a_mac_pipe: assert property (@(posedge clock) disable iff (reset)
      p_valid_ff |-> $past(d_valid_ff))
      else $error("accumulate without read data");

   // pair index stays within the half recursion
   a_pair_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_B_RD1) |-> (j_ff < pairs))
      else $error("lattice pair index out of range");

   // warm-up count never passes the store depth
   a_warmup_range: assert property (@(posedge clock) disable iff (reset)
      32'(warmup_ff) <= lfbr_pkg::MAX_ORDER)
      else $error("warm-up count out of range");
`endif

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the lpc tap build and residual engine
// ----------------------------------------------------------------------------
// a directed table runs first with order 1
// rows with an obvious residual carry it typed in, the rest use the predictor
// random phases follow: each writes the registers, loads every predictor
// slot the order needs, builds taps, then streams samples with noise mixed in
// residuals are compared in order against a queue of predicted words
// ----------------------------------------------------------------------------
module testbench;

   localparam int CYCLE_LIMIT = 4000000;

   // command code the block ignores
   localparam logic [1:0] CMD_SPARE = 2'd3;

   typedef struct {
      logic [1:0]  cmd;
      logic [7:0]  slot;
      logic [9:0]  pval;
      logic [31:0] smp;
      bit          last;
      bit          typed;      // residual typed in below
      logic [31:0] res;
   } stim_row_type;

   typedef struct {
      logic [31:0] res;
      bit          last;
   } residual_word_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_cmd;
   logic [7:0]         req_coef_index;
   logic signed [9:0]  req_predictor_value;
   logic signed [31:0] req_sample;
   logic               req_is_last;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_residual;
   logic               rsp_last_out;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [8:0]         csr_wdata;

   lpc_filter_build_and_residual DUT (.*);

   // mirror of the block state
   logic [8:0]  m_order;
   logic [3:0]  m_quant;
   logic [4:0]  m_dshift;
   logic [9:0]  m_pred [lfbr_pkg::MAX_ORDER];
   logic [31:0] m_work [lfbr_pkg::MAX_ORDER];
   logic [15:0] m_taps [lfbr_pkg::MAX_ORDER];
   logic [15:0] m_hist [lfbr_pkg::MAX_ORDER];
   int          m_warm;

   residual_word_type residual_q [$];
   int  n_errors;
   int  cycles;
   bit  calm;        // no idling on either side while set
   stim_row_type dir_rows [17];

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic int eff_order();
      if (m_order == 0) return 1;
      if (m_order > lfbr_pkg::MAX_ORDER) return lfbr_pkg::MAX_ORDER;
      return m_order;
   endfunction

   function automatic int eff_quant();
      if (m_quant == 0) return 1;
      if (m_quant > 14) return 14;
      return m_quant;
   endfunction

   // predictor times entry, rounded by 2^9, low 32 bits kept
   function automatic logic [31:0] lattice_mul(logic signed [9:0] p, logic [31:0] v);
      longint t;
      t = longint'(p) * longint'($signed(v)) + 256;
      t = t >>> 9;
      return t[31:0];
   endfunction

   function automatic void build_taps();
      int o, s;
      logic [31:0] y, v1, v2, nx, t;
      o = eff_order();
      s = 15 - eff_quant();
      y = 32'd1 << (s - 1);
      m_work[0] = 32'($signed(m_pred[0]) * 64);
      for (int i = 1; i < o; i++) begin
         for (int j = 0; j < (i + 1) / 2; j++) begin
            v1 = m_work[j];
            v2 = m_work[i-1-j];
            nx = v1 + lattice_mul(m_pred[i], v2);
            m_work[i-1-j] = v2 + lattice_mul(m_pred[i], v1);
            m_work[j] = nx;
         end
         m_work[i] = 32'($signed(m_pred[i]) * 64);
      end
      for (int k = 0; k < o; k++) begin
         t = m_work[o-1-k] + y;
         t = $signed(t) >>> s;
         m_taps[k] = 16'(32'd0 - t);
      end
      m_warm = 0;
   endfunction

   function automatic void shift_history(logic [15:0] h);
      int o;
      o = eff_order();
      for (int j = 0; j < o - 1; j++) m_hist[j] = m_hist[j+1];
      m_hist[o-1] = h;
   endfunction

   // updates the mirror; returns 1 with the residual when a word is due
   function automatic bit predict_word(logic [1:0] cmd, logic [7:0] slot,
                                       logic [9:0] pval, logic [31:0] smp, bit last,
                                       output residual_word_type w);
      int o, q;
      logic [15:0] h;
      logic [31:0] acc, pr;
      o = eff_order();
      q = eff_quant();
      w.res = '0;
      w.last = last;
      case (cmd)
         lfbr_pkg::CMD_LOAD: begin
            m_pred[slot] = pval;
            return 0;
         end
         lfbr_pkg::CMD_BUILD: begin
            build_taps();
            return 0;
         end
         lfbr_pkg::CMD_SAMPLE: begin
            acc = $signed(smp) >>> m_dshift;
            h = acc[15:0];
            if (m_warm < o) begin
               shift_history(h);
               m_warm = last ? 0 : m_warm + 1;
               return 0;
            end
            acc = 32'd1 << (q - 1);
            for (int j = 0; j < o; j++)
               acc += 32'(int'($signed(m_hist[j])) * int'($signed(m_taps[j])));
            pr = $signed(acc) >>> q;
            if ($signed(pr) < $signed(lfbr_pkg::CLIP_LO)) pr = lfbr_pkg::CLIP_LO;
            if ($signed(pr) > $signed(lfbr_pkg::CLIP_HI)) pr = lfbr_pkg::CLIP_HI;
            w.res = (pr << m_dshift) - smp;
            shift_history(h);
            if (last) m_warm = 0;
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      n_errors++;
   endtask

   // residual checker
   always @(posedge clock) begin
      residual_word_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (residual_q.size() == 0) begin
            report("unexpected word", rsp_residual, 'x);
         end else begin
            w = residual_q.pop_front();
            if (rsp_residual !== w.res) report("residual", rsp_residual, w.res);
            if (rsp_last_out !== w.last) report("last_out", rsp_last_out, w.last);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   // receiver stalls
   initial begin
      rsp_ready = 0;
      forever begin
         @(negedge clock);
         rsp_ready = calm ? 1'b1 : ($urandom_range(0, 99) < 70);
         if (!calm && $urandom_range(0, 99) == 0)
            repeat ($urandom_range(20, 80)) @(negedge clock);
      end
   end

   // send one word; a typed residual replaces the predicted one
   task automatic send_word(logic [1:0] cmd, logic [7:0] slot, logic [9:0] pval,
                            logic [31:0] smp, bit last, bit typed = 0,
                            logic [31:0] res = '0);
      residual_word_type w;
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1;
      req_cmd = cmd;
      req_coef_index = slot;
      req_predictor_value = pval;
      req_sample = smp;
      req_is_last = last;
      do @(posedge clock); while (!req_ready);
      if (predict_word(cmd, slot, pval, smp, last, w)) begin
         if (typed) w.res = res;
         residual_q.push_back(w);
      end
      @(negedge clock);
   endtask

   // hold the sender until every word is back and the block is idle
   task automatic drain();
      req_valid = 0;
      while (residual_q.size() != 0) @(posedge clock);
      do @(posedge clock); while (!req_ready);
      repeat (eff_order() + 10) @(posedge clock);
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [8:0] data);
      csr_valid = 1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         lfbr_pkg::CSR_ORDER:        m_order = data;
         lfbr_pkg::CSR_QUANT_SHIFT:  m_quant = data[3:0];
         lfbr_pkg::CSR_SAMPLE_SHIFT: m_dshift = data[4:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 0;
   endtask

   function automatic logic [31:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return 32'($signed($urandom_range(0, 2000)) - 1000);
         1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [9:0] rand_pred();
      case ($urandom_range(0, 7))
         0: return 10'h200;
         1: return 10'h1ff;
         default: return 10'($urandom);
      endcase
   endfunction

   task automatic run_phase(int ord, int qs, int ds);
      int o, n, rate, r;
      write_csr(lfbr_pkg::CSR_ORDER, 9'(ord));
      write_csr(lfbr_pkg::CSR_QUANT_SHIFT, 9'(qs));
      write_csr(lfbr_pkg::CSR_SAMPLE_SHIFT, 9'(ds));
      calm = ($urandom_range(0, 3) == 0);
      o = eff_order();
      // every slot the build reads gets written first
      for (int i = 0; i < o; i++)
         send_word(lfbr_pkg::CMD_LOAD, 8'(i), rand_pred(), '0, 0);
      send_word(lfbr_pkg::CMD_BUILD, '0, '0, '0, 0);
      n = o + ((o > 64) ? 20 : 50);
      rate = 3 * o + 8;
      for (int k = 0; k < n; k++) begin
         if (k == 40) drain();
         r = $urandom_range(0, 59);
         if (r == 0)
            send_word(CMD_SPARE, 8'($urandom), 10'($urandom), $urandom, 1'($urandom));
         else if (r == 1)
            send_word(lfbr_pkg::CMD_LOAD, 8'($urandom), rand_pred(), '0, 0);
         else if (r == 2 && o <= 64)
            send_word(lfbr_pkg::CMD_BUILD, 8'($urandom), '0, '0, 0);
         else
            send_word(lfbr_pkg::CMD_SAMPLE, 8'($urandom), 10'($urandom), rand_sample(),
                      $urandom_range(0, rate - 1) == 0);
         if ($urandom_range(0, 49) == 0) calm = ~calm;
      end
      drain();
   endtask

   initial begin
      cycles = 0;
      n_errors = 0;
      calm = 0;
      reset = 1;
      req_valid = 0;
      req_cmd = lfbr_pkg::CMD_LOAD;
      req_coef_index = '0;
      req_predictor_value = '0;
      req_sample = '0;
      req_is_last = 0;
      csr_valid = 0;
      csr_index = lfbr_pkg::CSR_ORDER;
      csr_wdata = '0;
      m_order = lfbr_pkg::ORDER_RST;
      m_quant = lfbr_pkg::QUANT_SHIFT_RST;
      m_dshift = lfbr_pkg::SAMPLE_SHIFT_RST;
      m_warm = 0;
      foreach (m_hist[i]) begin
         m_pred[i] = '0;
         m_work[i] = '0;
         m_taps[i] = '0;
         m_hist[i] = '0;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // order 1 with zero tap: prediction is zero, residual is minus sample
      dir_rows = '{
         '{lfbr_pkg::CMD_LOAD,   8'd0,   10'd0,    32'd0,        0, 0, 32'd0},
         '{lfbr_pkg::CMD_BUILD,  8'd0,   10'd0,    32'd0,        0, 0, 32'd0},
         '{lfbr_pkg::CMD_SAMPLE, 8'd0,   10'd0,    32'd5,        0, 0, 32'd0},
         '{lfbr_pkg::CMD_SAMPLE, 8'd0,   10'd0,    32'd100,      0, 1, -32'sd100},
         '{lfbr_pkg::CMD_SAMPLE, 8'd0,   10'd0,    32'h80000000, 0, 1, 32'h80000000},
         '{lfbr_pkg::CMD_SAMPLE, 8'd0,   10'd0,    32'h7fffffff, 0, 1, 32'h80000001},
         '{CMD_SPARE,            8'hff,  10'h3ff,  32'hffffffff, 1, 0, 32'd0},
         '{lfbr_pkg::CMD_SAMPLE, 8'd0,   10'd0,    32'd0,        1, 1, 32'd0},
         // last mark on a warm-up sample: no word
         '{lfbr_pkg::CMD_SAMPLE, 8'd0,   10'd0,    32'd7,        1, 0, 32'd0},
         // warm-up again after the last mark: no word
         '{lfbr_pkg::CMD_SAMPLE, 8'd0,   10'd0,    32'hffffffff, 0, 0, 32'd0},
         '{lfbr_pkg::CMD_LOAD,   8'd255, 10'h200,  32'd0,        0, 0, 32'd0},
         '{lfbr_pkg::CMD_LOAD,   8'd0,   10'h1ff,  32'd0,        0, 0, 32'd0},
         '{lfbr_pkg::CMD_BUILD,  8'd0,   10'd0,    32'd0,        0, 0, 32'd0},
         '{lfbr_pkg::CMD_SAMPLE, 8'd0,   10'd0,    32'h7fffffff, 0, 0, 32'd0},
         '{lfbr_pkg::CMD_SAMPLE, 8'd0,   10'd0,    32'h80000000, 0, 0, 32'd0},
         '{lfbr_pkg::CMD_LOAD,   8'd0,   10'h200,  32'd0,        0, 0, 32'd0},
         '{lfbr_pkg::CMD_SAMPLE, 8'd0,   10'd0,    32'd12345,    1, 0, 32'd0}
      };
      write_csr(lfbr_pkg::CSR_ORDER, 9'd1);
      foreach (dir_rows[i])
         send_word(dir_rows[i].cmd, dir_rows[i].slot, dir_rows[i].pval,
                   dir_rows[i].smp, dir_rows[i].last, dir_rows[i].typed,
                   dir_rows[i].res);
      drain();

      // register sweeps, out-of-range values included
      run_phase(32, 10, 0);
      run_phase(0, 0, 31);
      run_phase(2, 15, 16);
      run_phase(3, 14, 1);
      run_phase(256, 1, 0);
      run_phase(8, 7, 4);
      run_phase(300, 12, 16);
      run_phase(17, 9, 2);
      run_phase(64, 5, 0);
      run_phase(5, 13, 8);
      run_phase(1, 1, 31);

      if (n_errors == 0 && residual_q.size() == 0)
         $display("Regression PASS");
      else begin
         if (residual_q.size() != 0)
            report("words left over", residual_q.size(), 0);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
